/* src/pt32_pkg.sv */
// Shared types, constants and the base table for the 32-bit primality tester.
// Used by pt32_modmul, pt32_gcd and primality_test_32bit; depends on nothing.
`default_nettype none
package pt32_pkg;

    localparam logic [31:0] HASH_MULT = 32'hAD625B89;
    localparam int unsigned HASH_SHIFT = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_SPLIT,
        ST_REDUCE,
        ST_WAIT_RED,
        ST_EXP_SQ,
        ST_WAIT_SQ,
        ST_WAIT_MUL,
        ST_CHECK,
        ST_LOOP_SQ,
        ST_WAIT_LOOP,
        ST_HASH,
        ST_GCD_GO,
        ST_WAIT_GCD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] mcand;
        logic [31:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] u;
        logic [15:0] v;
    } gcd_req_t;

    typedef struct packed {
        logic done;
        logic coprime;
    } gcd_rsp_t;

    localparam logic [15:0] BASE_ROM [256] = '{
        16'd1216, 16'd1836, 16'd8885, 16'd4564, 16'd10978, 16'd5228, 16'd15613, 16'd13941,
        16'd1553, 16'd173, 16'd3615, 16'd3144, 16'd10065, 16'd9259, 16'd233, 16'd2362,
        16'd6244, 16'd6431, 16'd10863, 16'd5920, 16'd6408, 16'd6841, 16'd22124, 16'd2290,
        16'd45597, 16'd6935, 16'd4835, 16'd7652, 16'd1051, 16'd445, 16'd5807, 16'd842,
        16'd1534, 16'd22140, 16'd1282, 16'd1733, 16'd347, 16'd6311, 16'd14081, 16'd11157,
        16'd186, 16'd703, 16'd9862, 16'd15490, 16'd1720, 16'd17816, 16'd10433, 16'd49185,
        16'd2535, 16'd9158, 16'd2143, 16'd2840, 16'd664, 16'd29074, 16'd24924, 16'd1035,
        16'd41482, 16'd1065, 16'd10189, 16'd8417, 16'd130, 16'd4551, 16'd5159, 16'd48886,
        16'd786, 16'd1938, 16'd1013, 16'd2139, 16'd7171, 16'd2143, 16'd16873, 16'd188,
        16'd5555, 16'd42007, 16'd1045, 16'd3891, 16'd2853, 16'd23642, 16'd148, 16'd3585,
        16'd3027, 16'd280, 16'd3101, 16'd9918, 16'd6452, 16'd2716, 16'd855, 16'd990,
        16'd1925, 16'd13557, 16'd1063, 16'd6916, 16'd4965, 16'd4380, 16'd587, 16'd3214,
        16'd1808, 16'd1036, 16'd6356, 16'd8191, 16'd6783, 16'd14424, 16'd6929, 16'd1002,
        16'd840, 16'd422, 16'd44215, 16'd7753, 16'd5799, 16'd3415, 16'd231, 16'd2013,
        16'd8895, 16'd2081, 16'd883, 16'd3855, 16'd5577, 16'd876, 16'd3574, 16'd1925,
        16'd1192, 16'd865, 16'd7376, 16'd12254, 16'd5952, 16'd2516, 16'd20463, 16'd186,
        16'd5411, 16'd35353, 16'd50898, 16'd1084, 16'd2127, 16'd4305, 16'd115, 16'd7821,
        16'd1265, 16'd16169, 16'd1705, 16'd1857, 16'd24938, 16'd220, 16'd3650, 16'd1057,
        16'd482, 16'd1690, 16'd2718, 16'd4309, 16'd7496, 16'd1515, 16'd7972, 16'd3763,
        16'd10954, 16'd2817, 16'd3430, 16'd1423, 16'd714, 16'd6734, 16'd328, 16'd2581,
        16'd2580, 16'd10047, 16'd2797, 16'd155, 16'd5951, 16'd3817, 16'd54850, 16'd2173,
        16'd1318, 16'd246, 16'd1807, 16'd2958, 16'd2697, 16'd337, 16'd4871, 16'd2439,
        16'd736, 16'd37112, 16'd1226, 16'd527, 16'd7531, 16'd5418, 16'd7242, 16'd2421,
        16'd16135, 16'd7015, 16'd8432, 16'd2605, 16'd5638, 16'd5161, 16'd11515, 16'd14949,
        16'd748, 16'd5003, 16'd9048, 16'd4679, 16'd1915, 16'd7652, 16'd9657, 16'd660,
        16'd3054, 16'd15469, 16'd2910, 16'd775, 16'd14106, 16'd1749, 16'd136, 16'd2673,
        16'd61814, 16'd5633, 16'd1244, 16'd2567, 16'd4989, 16'd1637, 16'd1273, 16'd11423,
        16'd7974, 16'd7509, 16'd6061, 16'd531, 16'd6608, 16'd1088, 16'd1627, 16'd160,
        16'd6416, 16'd11350, 16'd921, 16'd306, 16'd18117, 16'd1238, 16'd463, 16'd1722,
        16'd996, 16'd3866, 16'd6576, 16'd6055, 16'd130, 16'd24080, 16'd7331, 16'd3922,
        16'd8632, 16'd2706, 16'd24108, 16'd32374, 16'd4237, 16'd15302, 16'd287, 16'd2296,
        16'd1220, 16'd20922, 16'd3350, 16'd2089, 16'd562, 16'd11745, 16'd163, 16'd11951
    };

endpackage
`default_nettype wire

/* src/primality_test_32bit.sv */
// Words 0..3 and even words are settled at classification; odd words go through strong tests.
// Each modular multiply runs in the bit-serial multiplier; each strong test
// runs one reduction, 32 squarings, one multiply per set bit of d and up to r-1 squarings.
// One word is in flight at a time; the next word is taken as soon as the previous result
// is handed to the output register.
// Reset (rst_n, async, active low) returns the sequencer to idle and drops any pending result.
`default_nettype none
module primality_test_32bit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] candidate,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             is_prime
);
    pt32_pkg::state_t state_reg, state_next;

    logic [31:0] n_reg, n_next;
    logic [31:0] d_reg, d_next;
    logic [4:0]  r_reg, r_next;
    logic [4:0]  i_reg, i_next;
    logic [4:0]  bit_reg, bit_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] ared_reg, ared_next;
    logic [7:0]  idx_reg, idx_next;
    logic [15:0] base_reg, base_next;
    logic        second_reg, second_next;
    logic        res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    logic        is_prime_reg, is_prime_next;

    pt32_pkg::mul_req_t mul_req;
    pt32_pkg::mul_rsp_t mul_rsp;
    pt32_pkg::gcd_req_t gcd_req;
    pt32_pkg::gcd_rsp_t gcd_rsp;
    logic               mul_busy;

    logic [31:0] nm1;
    logic [31:0] hash_prod;
    logic [15:0] base_val;
    logic        slot_free;

    assign nm1       = n_reg - 32'd1;
    assign hash_prod = n_reg * pt32_pkg::HASH_MULT;
    assign base_val  = second_reg ? base_reg : 16'd2;
    assign slot_free = !out_valid_reg || !out_stall;

    pt32_modmul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .rsp     (mul_rsp),
        .modulus (n_reg),
        .busy    (mul_busy)
    );

    pt32_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (gcd_req),
        .rsp   (gcd_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        r_next         = r_reg;
        i_next         = i_reg;
        bit_next       = bit_reg;
        x_next         = x_reg;
        ared_next      = ared_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        second_next    = second_reg;
        res_next       = res_reg;
        is_prime_next  = is_prime_reg;
        out_valid_next = out_valid_reg && out_stall;
        mul_req        = '0;
        gcd_req        = '0;

        unique case (state_reg)
            pt32_pkg::ST_IDLE:
            begin
                // Take the word; the output slot parts us from the consumer.
                if (in_valid)
                begin
                    n_next     = candidate;
                    state_next = pt32_pkg::ST_CLASS;
                end
            end
            pt32_pkg::ST_CLASS:
            begin
                second_next = 1'b0;
                d_next      = {1'b0, n_reg[31:1]};
                r_next      = 5'd1;
                if (n_reg < 32'd4)
                begin
                    res_next   = (n_reg >= 32'd2);
                    state_next = pt32_pkg::ST_DONE;
                end
                else if (!n_reg[0])
                begin
                    res_next   = 1'b0;
                    state_next = pt32_pkg::ST_DONE;
                end
                else
                    state_next = pt32_pkg::ST_SPLIT;
            end
            pt32_pkg::ST_SPLIT:
            begin
                // Shift out trailing zeros of n-1, one per cycle.
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[31:1]};
                    r_next = r_reg + 5'd1;
                end
                else
                    state_next = pt32_pkg::ST_REDUCE;
            end
            pt32_pkg::ST_REDUCE:
            begin
                // base mod n as 1 * base: the serial operand may exceed n.
                mul_req.start  = 1'b1;
                mul_req.mcand  = 32'd1;
                mul_req.mplier = {16'd0, base_val};
                state_next     = pt32_pkg::ST_WAIT_RED;
            end
            pt32_pkg::ST_WAIT_RED:
            begin
                if (mul_rsp.done)
                begin
                    ared_next  = mul_rsp.product;
                    x_next     = 32'd1;
                    bit_next   = 5'd31;
                    state_next = pt32_pkg::ST_EXP_SQ;
                end
            end
            pt32_pkg::ST_EXP_SQ:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = x_reg;
                mul_req.mplier = x_reg;
                state_next     = pt32_pkg::ST_WAIT_SQ;
            end
            pt32_pkg::ST_WAIT_SQ:
            begin
                if (mul_rsp.done)
                begin
                    x_next = mul_rsp.product;
                    if (d_reg[bit_reg])
                    begin
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = ared_reg;
                        mul_req.mplier = mul_rsp.product;
                        state_next     = pt32_pkg::ST_WAIT_MUL;
                    end
                    else if (bit_reg == 5'd0)
                        state_next = pt32_pkg::ST_CHECK;
                    else
                    begin
                        bit_next   = bit_reg - 5'd1;
                        state_next = pt32_pkg::ST_EXP_SQ;
                    end
                end
            end
            pt32_pkg::ST_WAIT_MUL:
            begin
                if (mul_rsp.done)
                begin
                    x_next = mul_rsp.product;
                    if (bit_reg == 5'd0)
                        state_next = pt32_pkg::ST_CHECK;
                    else
                    begin
                        bit_next   = bit_reg - 5'd1;
                        state_next = pt32_pkg::ST_EXP_SQ;
                    end
                end
            end
            pt32_pkg::ST_CHECK:
            begin
                i_next = 5'd1;
                if (x_reg == 32'd1 || x_reg == nm1)
                begin
                    if (second_reg)
                    begin
                        res_next   = 1'b1;
                        state_next = pt32_pkg::ST_DONE;
                    end
                    else
                        state_next = pt32_pkg::ST_HASH;
                end
                else if (r_reg > 5'd1)
                    state_next = pt32_pkg::ST_LOOP_SQ;
                else
                begin
                    res_next   = 1'b0;
                    state_next = pt32_pkg::ST_DONE;
                end
            end
            pt32_pkg::ST_LOOP_SQ:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = x_reg;
                mul_req.mplier = x_reg;
                state_next     = pt32_pkg::ST_WAIT_LOOP;
            end
            pt32_pkg::ST_WAIT_LOOP:
            begin
                if (mul_rsp.done)
                begin
                    x_next = mul_rsp.product;
                    if (mul_rsp.product == nm1)
                    begin
                        if (second_reg)
                        begin
                            res_next   = 1'b1;
                            state_next = pt32_pkg::ST_DONE;
                        end
                        else
                            state_next = pt32_pkg::ST_HASH;
                    end
                    else if ((i_reg + 5'd1) < r_reg)
                    begin
                        i_next     = i_reg + 5'd1;
                        state_next = pt32_pkg::ST_LOOP_SQ;
                    end
                    else
                    begin
                        res_next   = 1'b0;
                        state_next = pt32_pkg::ST_DONE;
                    end
                end
            end
            pt32_pkg::ST_HASH:
            begin
                idx_next   = hash_prod[31:pt32_pkg::HASH_SHIFT];
                state_next = pt32_pkg::ST_GCD_GO;
            end
            pt32_pkg::ST_GCD_GO:
            begin
                base_next     = pt32_pkg::BASE_ROM[idx_reg];
                gcd_req.start = 1'b1;
                gcd_req.u     = n_reg;
                gcd_req.v     = pt32_pkg::BASE_ROM[idx_reg];
                state_next    = pt32_pkg::ST_WAIT_GCD;
            end
            pt32_pkg::ST_WAIT_GCD:
            begin
                if (gcd_rsp.done)
                begin
                    if (gcd_rsp.coprime)
                    begin
                        second_next = 1'b1;
                        state_next  = pt32_pkg::ST_REDUCE;
                    end
                    else
                    begin
                        res_next   = 1'b0;
                        state_next = pt32_pkg::ST_DONE;
                    end
                end
            end
            pt32_pkg::ST_DONE:
            begin
                // Hold the verdict until the output slot is free.
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = res_reg;
                    state_next     = pt32_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pt32_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pt32_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        r_reg        <= r_next;
        i_reg        <= i_next;
        bit_reg      <= bit_next;
        x_reg        <= x_next;
        ared_reg     <= ared_next;
        idx_reg      <= idx_next;
        base_reg     <= base_next;
        second_reg   <= second_next;
        res_reg      <= res_next;
        is_prime_reg <= is_prime_next;
    end

    assign in_stall  = (state_reg != pt32_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

`ifndef SYNTHESIS
    // A new multiply never lands on one still running.
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_busy)
        else $error("multiply issued while multiplier busy");

    // An accepted word is classified in the next cycle.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == pt32_pkg::ST_CLASS))
        else $error("accepted word not classified");

    // Leaving the done state always presents a result.
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pt32_pkg::ST_DONE && slot_free) |=> out_valid)
        else $error("result not presented");
`endif
endmodule
`default_nettype wire

/* src/pt32_modmul.sv */
// Bit-serial modular multiplier: mcand * mplier mod modulus, one multiplier bit per cycle.
// Depends on pt32_pkg. mcand must be below modulus; mplier may be any 32-bit value.
`default_nettype none
module pt32_modmul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pt32_pkg::mul_req_t req,
    output pt32_pkg::mul_rsp_t     rsp,
    input  wire logic [31:0]       modulus,
    output logic                   busy
);
    logic [31:0] acc_reg, acc_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [33:0] sum;
    logic [33:0] n1;
    logic [33:0] n2;
    logic [33:0] red;

    // Doubling plus one addend stays below 3n: reduce by 2n or n.
    always_comb
    begin
        n1  = {2'b00, modulus};
        n2  = {1'b0, modulus, 1'b0};
        sum = {1'b0, acc_reg, 1'b0} + (b_reg[31] ? {2'b00, a_reg} : 34'd0);
        if (sum >= n2)
            red = sum - n2;
        else if (sum >= n1)
            red = sum - n1;
        else
            red = sum;
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = 32'd0;
            a_next    = req.mcand;
            b_next    = req.mplier;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = red[31:0];
            b_next   = {b_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;
    assign busy        = busy_reg;
endmodule
`default_nettype wire

/* src/pt32_gcd.sv */
// Binary gcd of an odd 32-bit word and a 16-bit base, one subtract or shift per cycle.
// Depends on pt32_pkg.
`default_nettype none
module pt32_gcd (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pt32_pkg::gcd_req_t req,
    output pt32_pkg::gcd_rsp_t     rsp
);
    logic [31:0] u_reg, u_next;
    logic [31:0] v_reg, v_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    // u stays odd; strip twos from v, then replace the pair by min and difference.
    always_comb
    begin
        u_next    = u_reg;
        v_next    = v_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            u_next    = req.u;
            v_next    = {16'd0, req.v};
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg == 32'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!v_reg[0])
                v_next = {1'b0, v_reg[31:1]};
            else if (u_reg > v_reg)
            begin
                u_next = v_reg;
                v_next = u_reg - v_reg;
            end
            else
                v_next = v_reg - u_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.coprime = (u_reg == 32'd1);
endmodule
`default_nettype wire
